### rtl/blrc_pkg.sv
// Shared types and codes for the base/limit register CPU executor.
// Used by every module under rtl; depends on nothing else.
package blrc_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_INDEX_W = 2;
	localparam logic [32:0] ACCESS_BYTES = 33'd4;

	// Command codes as they arrive on the input.
	localparam logic [3:0] CMD_SET     = 4'd0;
	localparam logic [3:0] CMD_ADD     = 4'd1;
	localparam logic [3:0] CMD_SUB     = 4'd2;
	localparam logic [3:0] CMD_JNZ     = 4'd3;
	localparam logic [3:0] CMD_LOAD    = 4'd4;
	localparam logic [3:0] CMD_STORE   = 4'd5;
	localparam logic [3:0] CMD_LOG     = 4'd6;
	localparam logic [3:0] CMD_SYSCALL = 4'd7;
	localparam logic [3:0] CMD_LDRET   = 4'd9;
	localparam logic [3:0] CMD_START   = 4'd10;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_SEG_BASE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEG_LIMIT = 2'd1;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_READ  = 2'd1;
	localparam logic [1:0] MEM_WRITE = 2'd2;

	localparam logic [1:0] STOP_SYSCALL = 2'd0;
	localparam logic [1:0] STOP_SEGV    = 2'd1;
	localparam logic [1:0] STOP_IRQ     = 2'd2;
	localparam logic [1:0] STOP_BADOP   = 2'd3;

	typedef enum logic [3:0] {
		OP_SET,
		OP_ADD,
		OP_SUB,
		OP_JNZ,
		OP_LOAD,
		OP_STORE,
		OP_LOG,
		OP_SYSCALL,
		OP_BAD,
		OP_LDRET,
		OP_START
	} op_t;

	typedef struct packed {
		logic [3:0]  command;
		logic [2:0]  reg_a;
		logic [2:0]  reg_b;
		logic [31:0] immediate;
		logic [3:0]  syscall_kind;
		logic        interrupt_pending;
		logic [31:0] load_data;
	} instr_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  reg_a;
		logic [2:0]  reg_b;
		logic [31:0] immediate;
		logic [3:0]  syscall_kind;
		logic        interrupt_pending;
		logic [31:0] load_data;
	} dec_t;

	typedef struct packed {
		logic [31:0] fetch_pc;
		logic [1:0]  mem_request;
		logic [31:0] phys_addr;
		logic [31:0] write_data;
		logic        log_valid;
		logic [31:0] log_value;
		logic        stopped;
		logic [1:0]  stop_reason;
		logic [3:0]  syscall_out;
	} result_t;

endpackage

### rtl/blrc_decode.sv
// Front end: classifies an incoming instruction into an operation class.
// Depends on blrc_pkg.
module blrc_decode
	import blrc_pkg::*;
(
	input  instr_t instr,
	output dec_t   dec
);

	always_comb begin
		dec.reg_a             = instr.reg_a;
		dec.reg_b             = instr.reg_b;
		dec.immediate         = instr.immediate;
		dec.syscall_kind      = instr.syscall_kind;
		dec.interrupt_pending = instr.interrupt_pending;
		dec.load_data         = instr.load_data;
		case (instr.command)
			CMD_SET:     dec.op = OP_SET;
			CMD_ADD:     dec.op = OP_ADD;
			CMD_SUB:     dec.op = OP_SUB;
			CMD_JNZ:     dec.op = OP_JNZ;
			CMD_LOAD:    dec.op = OP_LOAD;
			CMD_STORE:   dec.op = OP_STORE;
			CMD_LOG:     dec.op = OP_LOG;
			CMD_SYSCALL: dec.op = OP_SYSCALL;
			CMD_LDRET:   dec.op = OP_LDRET;
			CMD_START:   dec.op = OP_START;
			default:     dec.op = OP_BAD;
		endcase
	end

endmodule

### rtl/blrc_fifo.sv
// Small synchronous queue used between the front end, the execute stage and the output.
// Depends on blrc_pkg only for the common import convention.
module blrc_fifo
	import blrc_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/blrc_exec.sv
// Back end: register file, program counter, segment registers and the execute step.
// Depends on blrc_pkg.
module blrc_exec
	import blrc_pkg::*;
#(
	parameter int NUM_REGS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  dec_t                   dec,
	input  logic                   out_ready,
	output logic                   fire,
	output result_t                res,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	localparam int RIDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	logic [31:0] regs_q [NUM_REGS];
	logic [31:0] pc_q;
	logic        running_q;
	logic [2:0]  ld_dest_q;
	logic [31:0] seg_base_q;
	logic [31:0] seg_limit_q;

	logic        ra_ok, rb_ok, ld_ok;
	logic [31:0] a_val, b_val;
	logic [31:0] pc_d;
	logic        running_d;
	logic        ld_dest_en;
	logic        wr_en;
	logic [2:0]  wr_sel;
	logic [31:0] wr_data;
	logic [31:0] mem_addr;
	logic        legal;
	logic        stop_d;

	assign fire  = in_valid && out_ready;
	assign ra_ok = (32'(dec.reg_a) < NUM_REGS);
	assign rb_ok = (32'(dec.reg_b) < NUM_REGS);
	assign ld_ok = (32'(ld_dest_q) < NUM_REGS);
	assign a_val = ra_ok ? regs_q[RIDX_W'(dec.reg_a)] : '0;
	assign b_val = rb_ok ? regs_q[RIDX_W'(dec.reg_b)] : '0;

	// Store takes its address from reg_a, load from reg_b.
	assign mem_addr = (dec.op == OP_STORE) ? a_val : b_val;
	// The check is done one bit wider so that an address near the top cannot wrap.
	assign legal    = ({1'b0, mem_addr} + ACCESS_BYTES) <= {1'b0, seg_limit_q};

	always_comb begin
		pc_d       = pc_q;
		running_d  = running_q;
		ld_dest_en = 1'b0;
		wr_en      = 1'b0;
		wr_sel     = dec.reg_a;
		wr_data    = dec.immediate;
		stop_d     = 1'b0;
		res        = '0;
		case (dec.op)
			OP_START: begin
				pc_d      = dec.immediate;
				running_d = 1'b1;
			end
			OP_LDRET: begin
				wr_en   = ld_ok;
				wr_sel  = ld_dest_q;
				wr_data = dec.load_data;
			end
			default: begin
				if (running_q) begin
					pc_d = pc_q + 32'd1;
					case (dec.op)
						OP_SET: begin
							wr_en = ra_ok;
						end
						OP_ADD: begin
							wr_en   = ra_ok;
							wr_data = a_val + b_val;
						end
						OP_SUB: begin
							wr_en   = ra_ok;
							wr_data = a_val - b_val;
						end
						OP_JNZ: begin
							if (a_val != '0) begin
								pc_d = dec.immediate;
							end
						end
						OP_LOAD, OP_STORE: begin
							if (legal) begin
								res.mem_request = (dec.op == OP_LOAD) ? MEM_READ : MEM_WRITE;
								res.phys_addr   = seg_base_q + mem_addr;
								res.write_data  = (dec.op == OP_STORE) ? b_val : '0;
								ld_dest_en      = (dec.op == OP_LOAD);
							end else begin
								stop_d          = 1'b1;
								res.stop_reason = STOP_SEGV;
							end
						end
						OP_LOG: begin
							res.log_valid = 1'b1;
							res.log_value = a_val;
						end
						OP_SYSCALL: begin
							stop_d          = 1'b1;
							res.stop_reason = STOP_SYSCALL;
							res.syscall_out = dec.syscall_kind;
						end
						default: begin
							stop_d          = 1'b1;
							res.stop_reason = STOP_BADOP;
						end
					endcase
					// A stop caused by the instruction itself wins over the interrupt.
					if (stop_d) begin
						running_d = 1'b0;
					end else if (dec.interrupt_pending) begin
						running_d       = 1'b0;
						stop_d          = 1'b1;
						res.stop_reason = STOP_IRQ;
					end
				end
			end
		endcase
		res.stopped  = stop_d;
		res.fetch_pc = pc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			pc_q        <= '0;
			running_q   <= 1'b0;
			ld_dest_q   <= '0;
			seg_base_q  <= '0;
			seg_limit_q <= '0;
		end else begin
			if (fire) begin
				pc_q      <= pc_d;
				running_q <= running_d;
				if (ld_dest_en) begin
					ld_dest_q <= dec.reg_a;
				end
				if (wr_en) begin
					regs_q[RIDX_W'(wr_sel)] <= wr_data;
				end
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SEG_BASE:  seg_base_q  <= cfg_data;
					CFG_SEG_LIMIT: seg_limit_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

### rtl/base_limit_register_cpu_executor_core.sv
// Base/limit register CPU executor: decode, instruction queue, execute, result queue.
// A request is registered in the instruction queue, then executed, and its result is registered in the result queue.
// Throughput: one request per cycle while a request is queued and the result queue has room, set by the execute loop
// (register read, add or bounds compare, register and program counter write back).
// Reset clears the register file, program counter, run flag, segment registers and queues.
module base_limit_register_cpu_executor_core
	import blrc_pkg::*;
#(
	parameter int NUM_REGS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  instr_t                 instr,
	output logic                   empty,
	input  logic                   pop,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	dec_t    dec_in;
	dec_t    dec_q;
	logic    iq_empty;
	logic    rq_full;
	logic    exe_fire;
	result_t exe_res;

	assign cfg_ready = 1'b1;

	blrc_decode u_decode (
		.instr (instr),
		.dec   (dec_in)
	);

	blrc_fifo #(
		.WIDTH ($bits(dec_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_instr_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (dec_in),
		.full   (full),
		.pop    (exe_fire),
		.rdata  (dec_q),
		.empty  (iq_empty)
	);

	blrc_exec #(
		.NUM_REGS (NUM_REGS)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!iq_empty),
		.dec       (dec_q),
		.out_ready (!rq_full),
		.fire      (exe_fire),
		.res       (exe_res),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	blrc_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (exe_fire),
		.wdata  (exe_res),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

	// The execute stage only moves a request when both queues allow it.
	assert property (@(posedge clk) disable iff (!arst_n)
		exe_fire |-> (!iq_empty && !rq_full))
		else $error("execute fired without an instruction or result slot");

	// Without a stop, no reason or system call code is reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.stopped) |-> (result.stop_reason == STOP_SYSCALL &&
			result.syscall_out == 4'd0))
		else $error("stop reason reported without a stop");

	// A memory request goes out only alone or together with an interrupt stop.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.mem_request != MEM_NONE) |->
			(!result.log_valid && (!result.stopped || result.stop_reason == STOP_IRQ)))
		else $error("memory request combined with a fault or log");

endmodule

### test/base_limit_register_cpu_executor_core_test.sv
// Self-checking testbench for base_limit_register_cpu_executor_core.
// Needs blrc_pkg and the core from rtl. It predicts every result in-house and checks it,
// through directed programs and then random programs under several segment settings.
module base_limit_register_cpu_executor_core_test;
	import blrc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [3:0] CMD_UNUSED_LO = 4'd11;
	localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	instr_t instr;
	logic empty;
	logic pop;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	base_limit_register_cpu_executor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.instr(instr),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow CPU state and segment registers.
	logic [31:0] reg_file [0:7];
	logic [31:0] prog_ctr;
	logic cpu_running;
	logic [2:0] ld_dest;
	logic [31:0] seg_base;
	logic [31:0] seg_limit;

	instr_t pending_instrs [$];
	result_t expected_results [$];
	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int result_count;
	int cycle_count;
	bit req_accepted;
	bit gen_running;

	function automatic bit in_segment(input logic [31:0] addr);
		return ({1'b0, addr} + ACCESS_BYTES) <= {1'b0, seg_limit};
	endfunction

	task automatic execute_instr(input instr_t cur, output result_t res);
		logic [31:0] opa;
		logic [31:0] opb;
		res = '0;
		if (cur.command == CMD_START) begin
			prog_ctr = cur.immediate;
			cpu_running = 1'b1;
		end else if (cur.command == CMD_LDRET) begin
			reg_file[ld_dest] = cur.load_data;
		end else if (cpu_running) begin
			opa = reg_file[cur.reg_a];
			opb = reg_file[cur.reg_b];
			prog_ctr = prog_ctr + 32'd1;
			case (cur.command)
				CMD_SET: reg_file[cur.reg_a] = cur.immediate;
				CMD_ADD: reg_file[cur.reg_a] = opa + opb;
				CMD_SUB: reg_file[cur.reg_a] = opa - opb;
				CMD_JNZ: if (opa != 32'd0) prog_ctr = cur.immediate;
				CMD_LOAD: begin
					if (in_segment(opb)) begin
						res.mem_request = MEM_READ;
						res.phys_addr = seg_base + opb;
						ld_dest = cur.reg_a;
					end else begin
						res.stopped = 1'b1;
						res.stop_reason = STOP_SEGV;
					end
				end
				CMD_STORE: begin
					if (in_segment(opa)) begin
						res.mem_request = MEM_WRITE;
						res.phys_addr = seg_base + opa;
						res.write_data = opb;
					end else begin
						res.stopped = 1'b1;
						res.stop_reason = STOP_SEGV;
					end
				end
				CMD_LOG: begin
					res.log_valid = 1'b1;
					res.log_value = opa;
				end
				CMD_SYSCALL: begin
					res.stopped = 1'b1;
					res.stop_reason = STOP_SYSCALL;
					res.syscall_out = cur.syscall_kind;
				end
				default: begin
					res.stopped = 1'b1;
					res.stop_reason = STOP_BADOP;
				end
			endcase
			// A stop caused by the instruction itself wins over a pending interrupt.
			if (res.stopped) begin
				cpu_running = 1'b0;
			end else if (cur.interrupt_pending) begin
				cpu_running = 1'b0;
				res.stopped = 1'b1;
				res.stop_reason = STOP_IRQ;
			end
		end
		res.fetch_pc = prog_ctr;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("mismatch at result %0d, %s: got %h, expected %h",
			result_count, what, got, want);
	endtask

	// Input and output sampling at the rising edge.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		result_t pred;
		req_accepted = 1'b0;
		if (arst_n) begin
			if (pop && !empty) begin
				got = result;
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected", got.fetch_pc, '0);
				end else begin
					want = expected_results.pop_front();
					if (got.fetch_pc !== want.fetch_pc)
						report_mismatch("fetch_pc", got.fetch_pc, want.fetch_pc);
					if (got.mem_request !== want.mem_request)
						report_mismatch("mem_request", 32'(got.mem_request),
							32'(want.mem_request));
					if (got.phys_addr !== want.phys_addr)
						report_mismatch("phys_addr", got.phys_addr, want.phys_addr);
					if (got.write_data !== want.write_data)
						report_mismatch("write_data", got.write_data, want.write_data);
					if (got.log_valid !== want.log_valid)
						report_mismatch("log_valid", 32'(got.log_valid),
							32'(want.log_valid));
					if (got.log_value !== want.log_value)
						report_mismatch("log_value", got.log_value, want.log_value);
					if (got.stopped !== want.stopped)
						report_mismatch("stopped", 32'(got.stopped), 32'(want.stopped));
					if (got.stop_reason !== want.stop_reason)
						report_mismatch("stop_reason", 32'(got.stop_reason),
							32'(want.stop_reason));
					if (got.syscall_out !== want.syscall_out)
						report_mismatch("syscall_out", 32'(got.syscall_out),
							32'(want.syscall_out));
				end
				result_count++;
			end
			if (push && !full) begin
				execute_instr(instr, pred);
				expected_results.push_back(pred);
				void'(pending_instrs.pop_front());
				req_accepted = 1'b1;
			end
		end
	end

	// Request and pop driver at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			pop <= 1'b0;
		end else begin
			// A request that was not taken stays on the port unchanged.
			if (push && !req_accepted) begin
			end else if (pending_instrs.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				push <= 1'b1;
				instr <= pending_instrs[0];
			end else begin
				push <= 1'b0;
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_instr(input logic [3:0] cmd, input logic [2:0] ra,
			input logic [2:0] rb, input logic [31:0] imm, input logic [3:0] kind,
			input logic irq, input logic [31:0] ldata);
		instr_t item;
		item.command = cmd;
		item.reg_a = ra;
		item.reg_b = rb;
		item.immediate = imm;
		item.syscall_kind = kind;
		item.interrupt_pending = irq;
		item.load_data = ldata;
		pending_instrs.push_back(item);
	endtask

	task automatic wait_drained();
		while (pending_instrs.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Called at a falling edge; valid stays high across both writes.
	task automatic write_segment(input logic [31:0] base, input logic [31:0] limit);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SEG_BASE;
		cfg_data <= base;
		do @(posedge clk); while (!cfg_ready);
		seg_base = base;
		@(negedge clk);
		cfg_index <= CFG_SEG_LIMIT;
		cfg_data <= limit;
		do @(posedge clk); while (!cfg_ready);
		seg_limit = limit;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Values that land inside, on the edge of, and outside the current segment.
	function automatic logic [31:0] pick_value(input logic [31:0] limit);
		logic [31:0] v;
		case ($urandom_range(7))
			0: v = '0;
			1: v = '1;
			2, 3: begin
				if (limit >= ACCESS_BYTES[31:0])
					v = $urandom_range(limit - ACCESS_BYTES[31:0]);
				else
					v = $urandom_range(3);
			end
			4: v = limit - ACCESS_BYTES[31:0] + $urandom_range(3);
			5: v = $urandom_range(15);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic gen_programs(input int n);
		int made;
		int r;
		logic [3:0] cmd;
		logic irq;
		bit counted;
		made = 0;
		while (made < n) begin
			r = $urandom_range(99);
			if (!gen_running)
				cmd = (r < 75) ? CMD_START : 4'($urandom_range(15));
			else if (r < 14)
				cmd = CMD_SET;
			else if (r < 26)
				cmd = CMD_ADD;
			else if (r < 34)
				cmd = CMD_SUB;
			else if (r < 42)
				cmd = CMD_JNZ;
			else if (r < 58)
				cmd = CMD_LOAD;
			else if (r < 72)
				cmd = CMD_STORE;
			else if (r < 78)
				cmd = CMD_LOG;
			else if (r < 82)
				cmd = CMD_LDRET;
			else if (r < 85)
				cmd = CMD_SYSCALL;
			else if (r < 87)
				cmd = OP_BAD;
			else if (r < 89)
				cmd = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
			else if (r < 92)
				cmd = CMD_START;
			else
				cmd = CMD_SET;
			irq = ($urandom_range(29) == 0);
			counted = gen_running || cmd == CMD_START || cmd == CMD_LDRET;
			queue_instr(cmd, 3'($urandom_range(7)), 3'($urandom_range(7)),
				pick_value(seg_limit), 4'($urandom_range(15)), irq, $urandom);
			// Faults are not tracked here; the occasional start recovers from them.
			if (cmd == CMD_START)
				gen_running = 1'b1;
			else if (cmd != CMD_LDRET && (irq || cmd == CMD_SYSCALL || cmd == OP_BAD ||
					cmd > CMD_START))
				gen_running = 1'b0;
			if (counted)
				made++;
		end
	endtask

	task automatic run_phase(input logic [31:0] base, input logic [31:0] limit,
			input int sidle, input int rstall, input int n);
		wait_drained();
		write_segment(base, limit);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		gen_programs(n);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		instr = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SEG_BASE;
		cfg_data = '0;
		for (int i = 0; i < 8; i++)
			reg_file[i] = '0;
		prog_ctr = '0;
		cpu_running = 1'b0;
		ld_dest = '0;
		seg_base = '0;
		seg_limit = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		result_count = 0;
		gen_running = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_segment(32'h1000_0000, 32'h0000_0100);
		// Ignored while halted, and a load return with no load outstanding.
		queue_instr(CMD_SET, 3'd1, 3'd0, 32'hDEAD_BEEF, 4'd0, 1'b1, '0);
		queue_instr(CMD_LDRET, 3'd0, 3'd0, '0, 4'd0, 1'b0, 32'hFFFF_FFFF);
		// Start at the top of the address space so the first fetch wraps.
		queue_instr(CMD_START, 3'd0, 3'd0, 32'hFFFF_FFFF, 4'd0, 1'b1, '0);
		queue_instr(CMD_SET, 3'd1, 3'd0, 32'hFFFF_FFFF, 4'd0, 1'b0, '0);
		queue_instr(CMD_SET, 3'd2, 3'd0, 32'd1, 4'd0, 1'b0, '0);
		queue_instr(CMD_ADD, 3'd3, 3'd2, '0, 4'd0, 1'b0, '0);
		queue_instr(CMD_ADD, 3'd3, 3'd1, '0, 4'd0, 1'b0, '0);
		queue_instr(CMD_SUB, 3'd4, 3'd1, '0, 4'd0, 1'b0, '0);
		queue_instr(CMD_JNZ, 3'd4, 3'd0, 32'h0000_0040, 4'd0, 1'b0, '0);
		queue_instr(CMD_JNZ, 3'd3, 3'd0, 32'h0000_0080, 4'd0, 1'b0, '0);
		// Last legal word of the segment, then one byte past it.
		queue_instr(CMD_SET, 3'd5, 3'd0, 32'h0000_00FC, 4'd0, 1'b0, '0);
		queue_instr(CMD_LOAD, 3'd6, 3'd5, '0, 4'd0, 1'b0, '0);
		queue_instr(CMD_LDRET, 3'd0, 3'd0, '0, 4'd0, 1'b0, 32'hA5A5_5A5A);
		queue_instr(CMD_LOG, 3'd6, 3'd0, '0, 4'd0, 1'b0, '0);
		queue_instr(CMD_SET, 3'd5, 3'd0, 32'h0000_00FD, 4'd0, 1'b0, '0);
		queue_instr(CMD_STORE, 3'd5, 3'd6, '0, 4'd0, 1'b0, '0);
		// An address near the top must fault even though address plus four wraps.
		queue_instr(CMD_START, 3'd0, 3'd0, '0, 4'd0, 1'b0, '0);
		queue_instr(CMD_LOAD, 3'd7, 3'd1, '0, 4'd0, 1'b0, '0);
		// A store outside the segment with an interrupt reports the segment fault, not the interrupt.
		queue_instr(CMD_START, 3'd0, 3'd0, 32'h0000_0100, 4'd0, 1'b0, '0);
		queue_instr(CMD_STORE, 3'd0, 3'd4, '0, 4'd0, 1'b1, '0);
		// A system call with an interrupt reports the system call.
		queue_instr(CMD_START, 3'd0, 3'd0, 32'h8000_0000, 4'd0, 1'b0, '0);
		queue_instr(CMD_SYSCALL, 3'd7, 3'd7, '0, 4'd15, 1'b1, '0);
		queue_instr(CMD_START, 3'd0, 3'd0, 32'h0000_0010, 4'd0, 1'b0, '0);
		queue_instr(OP_BAD, 3'd0, 3'd0, '0, 4'd0, 1'b0, '0);
		queue_instr(CMD_START, 3'd0, 3'd0, 32'h0000_0020, 4'd0, 1'b0, '0);
		queue_instr(CMD_UNUSED_HI, 3'd7, 3'd7, 32'hFFFF_FFFF, 4'd0, 1'b0, '0);
		queue_instr(CMD_START, 3'd0, 3'd0, 32'h0000_0030, 4'd0, 1'b0, '0);
		queue_instr(CMD_LOG, 3'd0, 3'd0, '0, 4'd0, 1'b1, '0);
		queue_instr(CMD_ADD, 3'd1, 3'd1, '0, 4'd0, 1'b1, '0);

		run_phase(32'h0000_0000, 32'h0000_0400, 0, 0, 200);
		run_phase(32'hFFFF_FF00, 32'h0000_1000, 53, 0, 200);
		run_phase(32'h0000_0000, 32'h0000_0000, 0, 53, 150);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16, 16, 250);
		run_phase(32'h8000_0000, 32'h0000_0003, 0, 0, 150);
		run_phase(32'h1234_5678, 32'h0000_0004, 53, 0, 200);
		run_phase($urandom, $urandom, 16, 16, 200);
		run_phase(32'h0000_0000, 32'hFFFF_FFFC, 0, 53, 250);
		wait_drained();

		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
rtl/blrc_pkg.sv
rtl/blrc_decode.sv
rtl/blrc_fifo.sv
rtl/blrc_exec.sv
rtl/base_limit_register_cpu_executor_core.sv
test/base_limit_register_cpu_executor_core_test.sv
